// ===== hdl/dqs_pkg.sv =====
`timescale 1ns / 1ps
// shared types and codes for the bounded deque with search
// no dependencies; used by dqs_cell and bounded_deque_with_search
package dqs_pkg;

   localparam int WORD_W = 32;

   // operation codes
   localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
   localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
   localparam logic [2:0] OP_POP_FRONT  = 3'd2;
   localparam logic [2:0] OP_POP_BACK   = 3'd3;
   localparam logic [2:0] OP_FIND       = 3'd4;

   // status codes
   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_EMPTY = 2'd1;
   localparam logic [1:0] STATUS_FULL  = 2'd2;
   localparam logic [1:0] STATUS_MISS  = 2'd3;

   typedef struct packed {
      logic [2:0]               operation;
      logic signed [WORD_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic [1:0]               status;
      logic signed [WORD_W-1:0] removed_value;
      logic [3:0]               found_index;
      logic [4:0]               entry_count;
   } rsp_type;

   // per-cell move command
   typedef struct packed {
      logic take_left;
      logic take_right;
      logic load;
   } cell_ctl_type;

endpackage

// ===== hdl/dqs_cell.sv =====
`timescale 1ns / 1ps
// one storage cell of the deque ring: holds one word, takes a neighbor's word or a new one
// depends on dqs_pkg
module dqs_cell (
   input  logic                       clock,
   input  dqs_pkg::cell_ctl_type      ctl,
   input  logic [dqs_pkg::WORD_W-1:0] left_data,
   input  logic [dqs_pkg::WORD_W-1:0] right_data,
   input  logic [dqs_pkg::WORD_W-1:0] load_data,
   output logic [dqs_pkg::WORD_W-1:0] data
);
   import dqs_pkg::*;

   logic [WORD_W-1:0] data_ff;
   logic [WORD_W-1:0] data_in;

   always_comb begin
      data_in = data_ff;
      if (ctl.load) begin
         data_in = load_data;
      end else if (ctl.take_left) begin
         data_in = left_data;
      end else if (ctl.take_right) begin
         data_in = right_data;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule

// ===== hdl/bounded_deque_with_search.sv =====
`timescale 1ns / 1ps
// bounded deque of signed words kept in a ring of cells, front always in cell 0
// depends on dqs_pkg and dqs_cell
//
//   port group   dir   handshake            payload
//   req_         in    req_valid/req_stall  req_data  (dqs_pkg::req_type)
//   rsp_         out   rsp_valid/rsp_stall  rsp_data  (dqs_pkg::rsp_type)
//
// push front, push back, pop front and any request refused as full or empty register
// their result when taken. pop back and search rotate the whole ring once in S_SCAN;
// search compares cell 0 each step, pop back keeps the back entry; S_DONE posts the result.
// one request in flight; a new request waits for S_IDLE and a free result register.
// reset empties the deque; cell contents are not cleared.
module bounded_deque_with_search #(
   parameter int DEPTH = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  dqs_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output dqs_pkg::rsp_type rsp_data
);
   import dqs_pkg::*;

   localparam int IW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DONE} state_type;

   state_type         state_ff;
   logic [CW-1:0]     count_ff;
   logic [CW-1:0]     count_in;
   logic [IW-1:0]     step_ff;
   logic              found_ff;
   logic [IW-1:0]     hit_ff;
   logic [WORD_W-1:0] scan_data_ff;
   logic [2:0]        op_ff;
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   rsp_type           rsp_ff;

   logic              rsp_free;
   logic              accept;
   logic              full;
   logic              empty;
   logic              push_front_go;
   logic              push_back_go;
   logic              rotate;
   logic              start_scan;
   logic [1:0]        status_now;
   logic [WORD_W-1:0] removed_now;

   logic [WORD_W-1:0] cell_data [DEPTH];
   cell_ctl_type      cell_ctl  [DEPTH];

   logic [CW+4:0]     count_ext;
   logic [CW+4:0]     count_cur_ext;
   logic [CW+4:0]     count_dec_ext;
   logic [IW+3:0]     hit_ext;
   logic [CW-1:0]     step_wide;
   logic              last_step;

   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE) || !rsp_free;
   assign accept    = req_valid && !req_stall;
   assign full      = count_ff == CW'(DEPTH);
   assign empty     = count_ff == '0;

   assign step_wide     = CW'(step_ff);
   assign last_step     = step_ff == IW'(DEPTH - 1);
   assign count_ext     = {5'b0, count_in};
   assign count_cur_ext = {5'b0, count_ff};
   assign count_dec_ext = {5'b0, count_ff - CW'(1)};
   assign hit_ext       = {4'b0, hit_ff};

   // a result is posted, or the one held is kept while stalled
   assign rsp_valid_in = (accept && !start_scan) || (state_ff == S_DONE && rsp_free) ||
                         (rsp_valid_ff && rsp_stall);

   // request decode: outcomes of push and pop front, start of a scan for pop back and search
   always_comb begin
      push_front_go = 1'b0;
      push_back_go  = 1'b0;
      rotate        = 1'b0;
      start_scan    = 1'b0;
      status_now    = STATUS_OK;
      removed_now   = '0;
      count_in      = count_ff;
      if (state_ff == S_SCAN) begin
         rotate = 1'b1;
      end
      if (accept) begin
         case (req_data.operation)
            OP_PUSH_FRONT, OP_PUSH_BACK: begin
               if (full) begin
                  status_now = STATUS_FULL;
               end else begin
                  push_front_go = req_data.operation == OP_PUSH_FRONT;
                  push_back_go  = req_data.operation == OP_PUSH_BACK;
                  count_in      = count_ff + CW'(1);
               end
            end
            OP_POP_FRONT: begin
               if (empty) begin
                  status_now = STATUS_EMPTY;
               end else begin
                  removed_now = cell_data[0];
                  rotate      = 1'b1;
                  count_in    = count_ff - CW'(1);
               end
            end
            OP_POP_BACK: begin
               if (empty) begin
                  status_now = STATUS_EMPTY;
               end else begin
                  start_scan = 1'b1;
               end
            end
            OP_FIND: begin
               if (empty) begin
                  status_now = STATUS_MISS;
               end else begin
                  start_scan = 1'b1;
               end
            end
            default: begin
               status_now = STATUS_OK;
            end
         endcase
      end
   end

   // ring of cells: left neighbor feeds on push front, right neighbor on rotate
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      always_comb begin
         cell_ctl[i].load       = (push_front_go && i == 0) ||
                                  (push_back_go && count_ff == CW'(i));
         cell_ctl[i].take_left  = push_front_go && i != 0;
         cell_ctl[i].take_right = rotate;
      end

      dqs_cell u_cell (
         .clock      (clock),
         .ctl        (cell_ctl[i]),
         .left_data  (cell_data[(i + DEPTH - 1) % DEPTH]),
         .right_data (cell_data[(i + 1) % DEPTH]),
         .load_data  (req_data.value),
         .data       (cell_data[i])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         step_ff      <= '0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  op_ff        <= req_data.operation;
                  scan_data_ff <= req_data.value;
                  step_ff      <= '0;
                  found_ff     <= 1'b0;
                  hit_ff       <= '0;
                  if (start_scan) begin
                     state_ff <= S_SCAN;
                  end else begin
                     count_ff              <= count_in;
                     rsp_ff.status         <= status_now;
                     rsp_ff.removed_value  <= removed_now;
                     rsp_ff.found_index    <= '0;
                     rsp_ff.entry_count    <= count_ext[4:0];
                  end
               end
            end
            S_SCAN: begin
               // cell 0 holds the entry at position step_ff from the front
               if (op_ff == OP_POP_BACK) begin
                  if (step_wide == count_ff - CW'(1)) begin
                     scan_data_ff <= cell_data[0];
                  end
               end else if (!found_ff && step_wide < count_ff &&
                            cell_data[0] == scan_data_ff) begin
                  found_ff <= 1'b1;
                  hit_ff   <= step_ff;
               end
               step_ff <= step_ff + IW'(1);
               if (last_step) begin
                  state_ff <= S_DONE;
               end
            end
            S_DONE: begin
               if (rsp_free) begin
                  state_ff     <= S_IDLE;
                  if (op_ff == OP_POP_BACK) begin
                     count_ff             <= count_ff - CW'(1);
                     rsp_ff.status        <= STATUS_OK;
                     rsp_ff.removed_value <= scan_data_ff;
                     rsp_ff.found_index   <= '0;
                     rsp_ff.entry_count   <= count_dec_ext[4:0];
                  end else begin
                     rsp_ff.status        <= found_ff ? STATUS_OK : STATUS_MISS;
                     rsp_ff.removed_value <= '0;
                     rsp_ff.found_index   <= found_ff ? hit_ext[3:0] : 4'd0;
                     rsp_ff.entry_count   <= count_cur_ext[4:0];
                  end
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
